/* rtl/core/ovl_pkg.sv */
// Package for the ordered value list: list depth, count width, operation and
// status codes, and the command struct broadcast to the cell chain.
// No dependencies.
package ovl_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int VALUE_W    = 32;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'b01,
        FSM_EXEC = 2'b10
    } fsm_t;

    typedef struct packed {
        logic               capture;
        logic               commit;
        logic [1:0]         op;
        logic [VALUE_W-1:0] key;
    } cell_cmd_t;

endpackage

/* rtl/core/ordered_value_list.sv */
// Ordered value list: top level with the control sequencer, count, result
// register and the chain of ovl_cell instances. Depends on ovl_pkg, ovl_cell.
// Each item is compared when accepted and committed from the execute state;
// the result is registered at the commit, and no new item is taken until then.
// Commit waits while the result register is full and not taken.
// Reset: synchronous, active low; the list is empty after reset.
module ordered_value_list
    import ovl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // status[1:0], entry_count[6:2], zero pad[7]
);

    fsm_t               state_reg, state_next;
    logic [1:0]         op_reg;
    logic [VALUE_W-1:0] key_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         status_reg, status_next;
    logic [CNT_W+4:0]   count_ext;

    logic                 accept, commit, slot_free;
    cell_cmd_t            cmd;
    logic [VALUE_W-1:0]   value_arr [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] valid_vec;
    logic [LIST_DEPTH:0]  hit_chain;

    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == FSM_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign commit    = (state_reg == FSM_EXEC) && slot_free;

    assign cmd.capture = accept;
    assign cmd.commit  = commit;
    assign cmd.op      = op_reg;
    assign cmd.key     = accept ? s_tdata[VALUE_W-1:0] : key_reg;

    assign hit_chain[0] = 1'b0;

    for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
        logic               left_v;
        logic [VALUE_W-1:0] right_d;
        logic               right_v;
        if (i == 0) begin : g_first
            assign left_v = 1'b1;
        end else begin : g_mid
            assign left_v = valid_vec[i-1];
        end
        if (i == LIST_DEPTH - 1) begin : g_last
            assign right_d = value_arr[i];
            assign right_v = 1'b0;
        end else begin : g_inner
            assign right_d = value_arr[i+1];
            assign right_v = valid_vec[i+1];
        end
        ovl_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cmd),
            .left_valid  (left_v),
            .right_value (right_d),
            .right_valid (right_v),
            .hit_in      (hit_chain[i]),
            .hit_out     (hit_chain[i+1]),
            .value       (value_arr[i]),
            .valid       (valid_vec[i])
        );
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            FSM_IDLE: begin
                if (accept) begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC: begin
                if (slot_free) begin
                    state_next     = FSM_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = ST_DONE;
                    unique case (op_reg)
                        OP_APPEND: begin
                            if (valid_vec[LIST_DEPTH-1]) begin
                                status_next = ST_FULL;
                            end else begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_SEARCH, OP_DELETE: begin
                            if (!valid_vec[0]) begin
                                status_next = ST_EMPTY;
                            end else if (!hit_chain[LIST_DEPTH]) begin
                                status_next = ST_NOT_FOUND;
                            end else if (op_reg == OP_DELETE) begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        default: begin
                            status_next = ST_DONE;
                        end
                    endcase
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= FSM_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        if (accept) begin
            op_reg  <= s_tuser;
            key_reg <= s_tdata[VALUE_W-1:0];
        end
    end

    assign count_ext = {5'b0, count_reg};
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {1'b0, count_ext[4:0], status_reg};

    a_count_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == 32'(count_reg))
        else $error("count disagrees with valid cells");

    a_valid_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_vec & (valid_vec + 1'b1)) == '0)
        else $error("valid cells do not form a prefix");

    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == FSM_EXEC) && $stable(count_reg))
        else $error("accepted item did not enter commit cycle");

    a_delete_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && op_reg == OP_DELETE && valid_vec[0] && hit_chain[LIST_DEPTH])
        |=> (count_reg + 1'b1 == $past(count_reg)))
        else $error("delete with match did not shrink list");

endmodule

/* rtl/core/ovl_cell.sv */
// One cell of the list chain: holds one entry and its valid bit, compares it
// against the key, takes the key on append if it is the first free cell, and
// takes the right neighbor's entry to close a gap. Depends on ovl_pkg.
module ovl_cell
    import ovl_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cell_cmd_t          cmd,
    input  logic               left_valid,
    input  logic [VALUE_W-1:0] right_value,
    input  logic               right_valid,
    input  logic               hit_in,
    output logic               hit_out,
    output logic [VALUE_W-1:0] value,
    output logic               valid
);

    logic [VALUE_W-1:0] value_reg, value_next;
    logic               valid_reg, valid_next;
    logic               match_reg;

    assign hit_out = hit_in | match_reg;
    assign value   = value_reg;
    assign valid   = valid_reg;

    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (cmd.commit) begin
            if (cmd.op == OP_APPEND) begin
                if (!valid_reg && left_valid) begin
                    value_next = cmd.key;
                    valid_next = 1'b1;
                end
            end else if (cmd.op == OP_DELETE) begin
                if (hit_out) begin
                    value_next = right_value;
                    valid_next = right_valid;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        if (cmd.capture) begin
            match_reg <= valid_reg && (value_reg == cmd.key);
        end
    end

endmodule
